// File: rtl/core/kt_pkg.sv
// ----------------------------------------------------------------------------
// kt_pkg - keyword token recogniser package
// Sizes, case modes, word view type and the keyword table.
// ----------------------------------------------------------------------------
package kt_pkg;

  localparam int MAX_WORD_LEN = 8;
  localparam int NUM_KEYWORDS = 28;
  localparam int TABLE_SIZE   = 28;
  localparam int KEY_SLOTS    = 8;

  localparam int CHAR_W  = 8;
  localparam int TOKEN_W = 5;
  localparam int COUNT_W = $clog2(MAX_WORD_LEN + 1);
  localparam int KLEN_W  = $clog2(KEY_SLOTS + 1);

  // entries actually searched and byte slots actually compared
  localparam int TABLE_N   = (NUM_KEYWORDS < TABLE_SIZE) ? NUM_KEYWORDS : TABLE_SIZE;
  localparam int CMP_SLOTS = (KEY_SLOTS < MAX_WORD_LEN) ? KEY_SLOTS : MAX_WORD_LEN;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_LOWER = 2'd1;
  localparam logic [1:0] MODE_UPPER = 2'd2;

  localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

  typedef logic [MAX_WORD_LEN-1:0][CHAR_W-1:0] word_buf_t;

  typedef struct packed {
    word_buf_t          buffer;
    logic [COUNT_W-1:0] count;
    logic               reject;
  } word_view_t;

  // text left-justified: first character in the top byte, zero padded
  localparam logic [8*KEY_SLOTS-1:0] KW_TEXT [TABLE_SIZE] = '{
    {"AFTER", 24'h0}, "ALLOCATE",         {"ALT", 40'h0},    {"AND", 40'h0},
    {"ANY", 40'h0},   {"BYTE", 32'h0},    {"CHAN", 32'h0},   {"DEF", 40'h0},
    {"FALSE", 24'h0}, {"FOR", 40'h0},     {"IF", 48'h0},     {"LOAD", 32'h0},
    {"NOT", 40'h0},   {"NOW", 40'h0},     {"OR", 48'h0},     {"PAR", 40'h0},
    {"PLACED", 16'h0}, {"PORT", 32'h0},   {"PRI", 40'h0},    {"PROC", 32'h0},
    {"SEQ", 40'h0},   {"SKIP", 32'h0},    {"TABLE", 24'h0},  {"TRUE", 32'h0},
    {"VALUE", 24'h0}, {"VAR", 40'h0},     {"WAIT", 32'h0},   {"WHILE", 24'h0}
  };

  localparam logic [KLEN_W-1:0] KW_LEN [TABLE_SIZE] = '{
    4'd5, 4'd8, 4'd3, 4'd3, 4'd3, 4'd4, 4'd4, 4'd3, 4'd5, 4'd3, 4'd2, 4'd4,
    4'd3, 4'd3, 4'd2, 4'd3, 4'd6, 4'd4, 4'd3, 4'd4, 4'd3, 4'd4, 4'd5, 4'd4,
    4'd5, 4'd3, 4'd4, 4'd5
  };

endpackage

// File: rtl/core/kt_if.sv
// ----------------------------------------------------------------------------
// kt_if - channel interfaces
// Character input channel and token result channel, valid/ready.
// ----------------------------------------------------------------------------
interface kt_char_if;
  logic                      valid;
  logic                      ready;
  logic [kt_pkg::CHAR_W-1:0] char_code;
  logic                      word_end;

  modport source (output valid, output char_code, output word_end, input ready);
  modport sink   (input valid, input char_code, input word_end, output ready);
endinterface

interface kt_token_if;
  logic                       valid;
  logic                       ready;
  logic [kt_pkg::TOKEN_W-1:0] token_code;
  logic                       is_keyword;

  modport source (output valid, output token_code, output is_keyword, input ready);
  modport sink   (input valid, input token_code, input is_keyword, output ready);
endinterface

// File: rtl/core/kt_word_state.sv
// ----------------------------------------------------------------------------
// kt_word_state - word buffer and case tracking
// Folds and stores each accepted character, tracks case mode, length and rejection.
// ----------------------------------------------------------------------------
module kt_word_state (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic                      word_end,
  input  logic [kt_pkg::CHAR_W-1:0] char_code,
  output kt_pkg::word_view_t        view
);
  import kt_pkg::*;

  word_buf_t          word_buffer;
  logic [COUNT_W-1:0] char_count;
  logic [1:0]         case_mode;
  logic               reject_flag;

  word_buf_t          word_buffer_next;
  logic [COUNT_W-1:0] char_count_next;
  logic [1:0]         case_mode_next;
  logic               reject_flag_next;

  logic              is_low;
  logic              is_up;
  logic              store;
  logic [CHAR_W-1:0] folded;

  assign is_low = (char_code >= 8'h61) && (char_code <= 8'h7A);
  assign is_up  = (char_code >= 8'h41) && (char_code <= 8'h5A);

  always_comb begin
    word_buffer_next = word_buffer;
    char_count_next  = char_count;
    case_mode_next   = case_mode;
    reject_flag_next = reject_flag;
    store            = 1'b0;
    folded           = char_code;
    if (!reject_flag) begin
      if (int'(char_count) >= MAX_WORD_LEN) begin
        reject_flag_next = 1'b1;
      end else if (char_count == '0) begin
        store = 1'b1;
        if (is_low) begin
          case_mode_next = MODE_LOWER;
          folded         = char_code - CASE_OFFSET;
        end else begin
          case_mode_next = MODE_UPPER;
        end
      end else begin
        case (case_mode)
          MODE_LOWER: begin
            if (is_low) begin
              store  = 1'b1;
              folded = char_code - CASE_OFFSET;
            end else begin
              reject_flag_next = 1'b1;
            end
          end
          default: begin
            if (is_up) store = 1'b1;
            else reject_flag_next = 1'b1;
          end
        endcase
      end
    end
    if (store) begin
      for (int j = 0; j < MAX_WORD_LEN; j++) begin
        if (int'(char_count) == j) word_buffer_next[j] = folded;
      end
      char_count_next = char_count + COUNT_W'(1);
    end
  end

  assign view.buffer = word_buffer_next;
  assign view.count  = char_count_next;
  assign view.reject = reject_flag_next;

  // state returns to empty after each final character
  always_ff @(posedge clk) begin
    if (rst) begin
      word_buffer <= '0;
      char_count  <= '0;
      case_mode   <= MODE_IDLE;
      reject_flag <= 1'b0;
    end else if (step) begin
      if (word_end) begin
        word_buffer <= '0;
        char_count  <= '0;
        case_mode   <= MODE_IDLE;
        reject_flag <= 1'b0;
      end else begin
        word_buffer <= word_buffer_next;
        char_count  <= char_count_next;
        case_mode   <= case_mode_next;
        reject_flag <= reject_flag_next;
      end
    end
  end

endmodule

// File: rtl/core/kt_matcher.sv
// ----------------------------------------------------------------------------
// kt_matcher - parallel keyword compare
// Compares the folded word against every table entry at once.
// ----------------------------------------------------------------------------
module kt_matcher (
  input  kt_pkg::word_view_t         view,
  output logic [kt_pkg::TOKEN_W-1:0] token_code,
  output logic                       is_keyword
);
  import kt_pkg::*;

  logic [TABLE_N-1:0] hit;

  // unused buffer bytes and table padding are both zero, so length plus a
  // full-slot compare is an exact match
  always_comb begin
    for (int i = 0; i < TABLE_N; i++) begin
      hit[i] = !view.reject && (int'(view.count) == int'(KW_LEN[i]));
      for (int j = 0; j < CMP_SLOTS; j++) begin
        if (KW_TEXT[i][8*KEY_SLOTS-1-8*j -: 8] != view.buffer[j]) hit[i] = 1'b0;
      end
    end
  end

  // lowest index wins
  always_comb begin
    token_code = TOKEN_W'(NUM_KEYWORDS);
    is_keyword = 1'b0;
    for (int i = TABLE_N - 1; i >= 0; i--) begin
      if (hit[i]) begin
        token_code = TOKEN_W'(i);
        is_keyword = 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/keyword_token_recognizer_core.sv
// ----------------------------------------------------------------------------
// keyword_token_recognizer_core - keyword token recogniser top level
// Input register, word state update with parallel compare, result register.
// ----------------------------------------------------------------------------
// path: a final character passes the input register and then the result register to reach its token
// throughput: one character per cycle; the input register and word state
//   stall only while a final character meets an untaken token
// reset: synchronous rst empties both registers and the word state
module keyword_token_recognizer_core (
  input  logic       clk,
  input  logic       rst,
  kt_char_if.sink    char_ch,
  kt_token_if.source token_ch
);
  import kt_pkg::*;

  logic              s1_valid;
  logic [CHAR_W-1:0] s1_char;
  logic              s1_end;

  logic               out_valid;
  logic [TOKEN_W-1:0] out_code;
  logic               out_kw;

  logic               s1_stall;
  logic               step;
  word_view_t         view;
  logic [TOKEN_W-1:0] match_code;
  logic               match_kw;

  assign s1_stall      = s1_valid && s1_end && out_valid && !token_ch.ready;
  assign step          = s1_valid && !s1_stall;
  assign char_ch.ready = !s1_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (char_ch.ready) begin
      s1_valid <= char_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_ch.valid && char_ch.ready) begin
      s1_char <= char_ch.char_code;
      s1_end  <= char_ch.word_end;
    end
  end

  kt_word_state u_state (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .word_end  (s1_end),
    .char_code (s1_char),
    .view      (view)
  );

  kt_matcher u_match (
    .view       (view),
    .token_code (match_code),
    .is_keyword (match_kw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && s1_end) begin
      out_valid <= 1'b1;
    end else if (token_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && s1_end) begin
      out_code <= match_code;
      out_kw   <= match_kw;
    end
  end

  assign token_ch.valid      = out_valid;
  assign token_ch.token_code = out_code;
  assign token_ch.is_keyword = out_kw;

endmodule

// File: rtl/core/kt_checker.sv
// ----------------------------------------------------------------------------
// kt_checker - port-level checks
// Watches the top level ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module kt_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       tok_valid,
  input logic                       tok_ready,
  input logic [kt_pkg::TOKEN_W-1:0] tok_code,
  input logic                       tok_kw
);
  import kt_pkg::*;

  // no token may be offered straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !tok_valid)
    else $error("token valid after reset");

  // a stalled token stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    tok_valid && !tok_ready |=> tok_valid && $stable(tok_code) && $stable(tok_kw))
    else $error("stalled token changed");

  // keyword flag and code agree
  a_code_kw: assert property (@(posedge clk) disable iff (rst)
    tok_valid |-> (tok_kw == (int'(tok_code) != NUM_KEYWORDS)))
    else $error("keyword flag disagrees with token code");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    tok_valid |-> (int'(tok_code) <= NUM_KEYWORDS))
    else $error("token code out of range");

endmodule

bind keyword_token_recognizer_core kt_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .tok_valid (token_ch.valid),
  .tok_ready (token_ch.ready),
  .tok_code  (token_ch.token_code),
  .tok_kw    (token_ch.is_keyword)
);

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench - keyword token recogniser testbench
// Streams words a character at a time into the core and predicts each token
// locally: case folding, length and case-break rejection, exact keyword
// match. Tokens are compared in order, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import kt_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int STALL_LIMIT  = 2000;
  localparam int IDLE_PCT     = 13;

  typedef struct packed {
    logic [TOKEN_W-1:0] token_code;
    logic               is_keyword;
  } token_t;

  logic clk;
  logic rst;

  kt_char_if  char_ch ();
  kt_token_if token_ch ();

  keyword_token_recognizer_core uut (
    .clk      (clk),
    .rst      (rst),
    .char_ch  (char_ch),
    .token_ch (token_ch)
  );

  string kw_names [NUM_KEYWORDS] = '{
    "AFTER", "ALLOCATE", "ALT", "AND", "ANY", "BYTE", "CHAN", "DEF", "FALSE",
    "FOR", "IF", "LOAD", "NOT", "NOW", "OR", "PAR", "PLACED", "PORT", "PRI",
    "PROC", "SEQ", "SKIP", "TABLE", "TRUE", "VALUE", "VAR", "WAIT", "WHILE"
  };

  // local copy of the word state
  logic [CHAR_W-1:0] pw_buf [MAX_WORD_LEN];
  int                pw_count;
  logic [1:0]        pw_mode;
  bit                pw_reject;

  token_t            expected_tokens [$];
  logic [CHAR_W-1:0] word_chars [$];
  int                chars_sent;
  int                fail_count = 0;
  int                stall_cycles = 0;
  bit                idle_on;

  function automatic bit is_lower(logic [CHAR_W-1:0] c);
    return c >= 8'h61 && c <= 8'h7A;
  endfunction

  function automatic bit is_upper(logic [CHAR_W-1:0] c);
    return c >= 8'h41 && c <= 8'h5A;
  endfunction

  function automatic void clear_word();
    foreach (pw_buf[i]) pw_buf[i] = '0;
    pw_count  = 0;
    pw_mode   = MODE_IDLE;
    pw_reject = 1'b0;
  endfunction

  function automatic void fold_char(logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] f;
    f = c;
    if (pw_reject) return;
    if (pw_count >= MAX_WORD_LEN) begin
      pw_reject = 1'b1;
      return;
    end
    if (pw_count == 0) begin
      if (is_lower(c)) begin
        pw_mode = MODE_LOWER;
        f = c - 8'h20;
      end else begin
        pw_mode = MODE_UPPER;
      end
    end else if (pw_mode == MODE_LOWER) begin
      if (!is_lower(c)) begin
        pw_reject = 1'b1;
        return;
      end
      f = c - 8'h20;
    end else if (!is_upper(c)) begin
      pw_reject = 1'b1;
      return;
    end
    pw_buf[pw_count] = f;
    pw_count++;
  endfunction

  function automatic logic [TOKEN_W-1:0] lookup_token();
    bit same;
    if (pw_reject || pw_count == 0) return TOKEN_W'(NUM_KEYWORDS);
    for (int i = 0; i < NUM_KEYWORDS; i++) begin
      if (kw_names[i].len() == pw_count) begin
        same = 1'b1;
        for (int j = 0; j < pw_count; j++)
          if (kw_names[i][j] != pw_buf[j]) same = 1'b0;
        if (same) return TOKEN_W'(i);
      end
    end
    return TOKEN_W'(NUM_KEYWORDS);
  endfunction

  function automatic void record_char(logic [CHAR_W-1:0] c, logic e);
    token_t t;
    fold_char(c);
    if (e) begin
      t.token_code = lookup_token();
      t.is_keyword = (t.token_code < NUM_KEYWORDS);
      expected_tokens.push_back(t);
      clear_word();
    end
  endfunction

  function automatic logic [CHAR_W-1:0] random_letter();
    logic [CHAR_W-1:0] c;
    c = 8'h41 + CHAR_W'($urandom_range(25, 0));
    if ($urandom_range(1, 0)) c = c + 8'h20;
    return c;
  endfunction

  // ---- clock and reset ----

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---- sending ----

  task automatic send_char(input logic [CHAR_W-1:0] c, input logic e);
    while (idle_on && $urandom_range(99, 0) < IDLE_PCT) begin
      char_ch.valid <= 1'b0;
      @(posedge clk);
    end
    char_ch.valid     <= 1'b1;
    char_ch.char_code <= c;
    char_ch.word_end  <= e;
    do @(posedge clk); while (!char_ch.ready);
    record_char(c, e);
    chars_sent++;
  endtask

  task automatic send_word();
    foreach (word_chars[i]) send_char(word_chars[i], i == word_chars.size() - 1);
  endtask

  task automatic load_text(input string s);
    word_chars.delete();
    for (int i = 0; i < s.len(); i++) word_chars.push_back(s[i]);
  endtask

  // keyword spellings with the odd corruption, or plain noise
  task automatic make_word(input int noise_pct);
    int k;
    int n;
    int p;
    word_chars.delete();
    if ($urandom_range(99, 0) >= noise_pct) begin
      k = $urandom_range(NUM_KEYWORDS - 1, 0);
      load_text(kw_names[k]);
      case ($urandom_range(2, 0))
        0: foreach (word_chars[i]) word_chars[i] = word_chars[i] + 8'h20;
        1: ;
        default: word_chars[0] = CHAR_W'($urandom_range(255, 0));
      endcase
      if ($urandom_range(99, 0) < 30) begin
        p = $urandom_range(word_chars.size() - 1, 0);
        case ($urandom_range(3, 0))
          0: word_chars[p] = CHAR_W'($urandom_range(255, 0));
          1: word_chars.push_back(random_letter());
          2: if (word_chars.size() > 1) void'(word_chars.pop_back());
          default: word_chars[p] = word_chars[p] ^ 8'h20;
        endcase
      end
    end else begin
      n = $urandom_range(12, 1);
      for (int i = 0; i < n; i++)
        word_chars.push_back($urandom_range(1, 0) ? random_letter()
                                                  : 8'($urandom_range(255, 0)));
    end
  endtask

  // ---- token checking and sink idling ----

  always @(posedge clk) begin
    token_t got;
    token_t want;
    if (!rst && token_ch.valid && token_ch.ready) begin
      got.token_code = token_ch.token_code;
      got.is_keyword = token_ch.is_keyword;
      if (expected_tokens.size() == 0) begin
        $display("%0t: unexpected token, actual token_code %0d is_keyword %0d",
                 $time, got.token_code, got.is_keyword);
        fail_count++;
      end else begin
        want = expected_tokens.pop_front();
        if (got.token_code !== want.token_code) begin
          $display("%0t: token_code mismatch, expected %0d, actual %0d",
                   $time, want.token_code, got.token_code);
          fail_count++;
        end
        if (got.is_keyword !== want.is_keyword) begin
          $display("%0t: is_keyword mismatch, expected %0d, actual %0d",
                   $time, want.is_keyword, got.is_keyword);
          fail_count++;
        end
      end
    end
    token_ch.ready <= !(idle_on && $urandom_range(99, 0) < IDLE_PCT);
  end

  // ---- watchdog: cycles with no transfer on either channel ----

  always @(posedge clk) begin
    if (rst || (char_ch.valid && char_ch.ready) || (token_ch.valid && token_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("** keyword_token_recognizer_core: FAILED **");
      $finish;
    end
  end

  // ---- tests ----

  task automatic test_directed();
    load_text("if");       send_word();
    load_text("ALLOCATE"); send_word();
    load_text("allocatex"); send_word();    // one past the buffer
    load_text("while");    send_word();
    load_text("Or");       send_word();     // case break after the first character
    word_chars = '{8'h00}; send_word();
    word_chars = '{8'hFF}; send_word();
  endtask

  task automatic test_keyword_stream(input int n_chars);
    int target;
    target = chars_sent + n_chars;
    while (chars_sent < target) begin
      make_word(20);
      send_word();
    end
  endtask

  task automatic test_back_to_back(input int n_chars);
    idle_on = 1'b0;
    test_keyword_stream(n_chars);
    idle_on = 1'b1;
  endtask

  task automatic test_noise(input int n_chars);
    int target;
    target = chars_sent + n_chars;
    while (chars_sent < target) begin
      make_word(70);
      send_word();
    end
  endtask

  initial begin
    rst               = 1'b1;
    idle_on           = 1'b1;
    chars_sent        = 0;
    char_ch.valid     <= 1'b0;
    char_ch.char_code <= '0;
    char_ch.word_end  <= 1'b0;
    clear_word();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_keyword_stream(650);
    test_back_to_back(350);
    test_noise(450);

    char_ch.valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (fail_count == 0)
      $display("** keyword_token_recognizer_core: PASSED **");
    else
      $display("** keyword_token_recognizer_core: FAILED **");
    $finish;
  end

endmodule
